>>> rtl/core/rhh_pkg.sv
// Shared constants and types of the Robin Hood hash table.
package rhh_pkg;

	localparam int LOG2_CAP_DEF = 10;
	localparam int KEY_BYTES = 8;

	localparam logic [3:0] SIZE_LOG2_RST = 4'd10;
	localparam logic [10:0] FILL_LIMIT_RST = 11'd859;

	localparam logic CFG_SIZE_LOG2 = 1'b0;
	localparam logic CFG_FILL_LIMIT = 1'b1;

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_PUT = 2'd1;
	localparam logic [1:0] OP_DEL = 2'd2;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_NOKEY = 3'd1;
	localparam logic [2:0] STAT_FULL = 3'd2;
	localparam logic [2:0] STAT_INVALID = 3'd3;
	localparam logic [2:0] STAT_TOOBIG = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PRB_RD,
		S_PRB_EV,
		S_ROOM_RD,
		S_ROOM_EV,
		S_INS_RD,
		S_INS_EV,
		S_DEL_RD,
		S_DEL_EV,
		S_DONE
	} state_t;

endpackage

>>> rtl/core/rhh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rhh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/robin_hood_hash_table.sv
// Robin Hood hash table: sequencer around one slot RAM.
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with done high and cannot be held off. After reset the
// block sweeps every slot to empty with busy high. Invalid requests (bad opcode
// or empty key) and oversized keys go straight to the result. Otherwise a
// request probes from its home bucket, then an insert scans for a free slot and
// walks the displacement chain, or a delete shifts entries back, before the
// result; every slot visited takes a read state and an evaluate state, since
// the slot RAM's read is registered. Configuration writes are taken at any
// time but only meant while idle.
module robin_hood_hash_table #(
	parameter int LOG2_CAP = rhh_pkg::LOG2_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] hash,
	input  logic [3:0]  key_len,
	input  logic [63:0] key_bytes,
	input  logic [31:0] put_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] value_out,
	output logic [10:0] entry_count,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import rhh_pkg::*;

	localparam int AW = LOG2_CAP;
	localparam int DW = LOG2_CAP + 1;
	localparam int CW = (DW > 11) ? DW : 11;

	typedef struct packed {
		logic [3:0]    len;
		logic [63:0]   key;
		logic [AW-1:0] disp;
		logic [31:0]   value;
	} entry_t;

	state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d, pos_q, pos_d, pip_q, pip_d, home_q, home_d;
	logic          have_pip_q, have_pip_d;
	logic [DW-1:0] dist_q, dist_d, step_q, step_d;
	entry_t        carry_q, carry_d;
	logic [1:0]    op_q, op_d;
	logic [3:0]    len_q, len_d;
	logic [63:0]   key_q, key_d;
	logic [31:0]   nv_q, nv_d, vout_q, vout_d;
	logic [2:0]    status_q, status_d;
	logic [10:0]   count_q, count_d;
	logic [3:0]    size_log2_q;
	logic [10:0]   fill_limit_q;

	logic [4:0]    lg;
	logic [AW-1:0] mask;
	logic [DW-1:0] nb;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata, e;
	logic          e_gt, e_eq, carry_lt;
	logic [AW-1:0] p_sel;

	function automatic logic key_lt(input logic [3:0] la, input logic [63:0] ka,
			input logic [3:0] lb, input logic [63:0] kb);
		return (la < lb) || (la == lb && ka < kb);
	endfunction

	// keep the first len bytes, zero the rest
	function automatic logic [63:0] key_mask(input logic [3:0] len, input logic [63:0] k);
		logic [63:0] r;
		r = k;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) >= len) begin
				r[63-8*b -: 8] = 8'h00;
			end
		end
		return r;
	endfunction

	rhh_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(1 << LOG2_CAP)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(idx_q),
		.rdata(e)
	);

	always_comb begin
		if (size_log2_q < 4'd3) begin
			lg = 5'd3;
		end else if ({1'b0, size_log2_q} > 5'(AW)) begin
			lg = 5'(AW);
		end else begin
			lg = {1'b0, size_log2_q};
		end
	end

	assign mask = {AW{1'b1}} >> (5'(AW) - lg);
	assign nb = DW'(mask) + DW'(1);

	assign e_gt = key_lt(len_q, key_q, e.len, e.key);
	assign e_eq = (e.len == len_q) && (e.key == key_q);
	assign carry_lt = key_lt(carry_q.len, carry_q.key, e.len, e.key);
	assign p_sel = have_pip_q ? pip_q : idx_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		pos_d = pos_q;
		pip_d = pip_q;
		home_d = home_q;
		have_pip_d = have_pip_q;
		dist_d = dist_q;
		step_d = step_q;
		carry_d = carry_q;
		op_d = op_q;
		len_d = len_q;
		key_d = key_q;
		nv_d = nv_q;
		vout_d = vout_q;
		status_d = status_q;
		count_d = count_q;
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				idx_d = idx_q + AW'(1);
				if (idx_q == {AW{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					op_d = opcode;
					len_d = key_len;
					key_d = key_mask(key_len, key_bytes);
					nv_d = put_value;
					vout_d = '0;
					home_d = hash[AW-1:0] & mask;
					idx_d = hash[AW-1:0] & mask;
					dist_d = '0;
					have_pip_d = 1'b0;
					priority if (opcode > OP_DEL || key_len == 4'd0) begin
						status_d = STAT_INVALID;
						state_d = S_DONE;
					end else if (key_len > 4'(KEY_BYTES)) begin
						status_d = STAT_TOOBIG;
						state_d = S_DONE;
					end else begin
						state_d = S_PRB_RD;
					end
				end
			end
			S_PRB_RD: state_d = S_PRB_EV;
			S_PRB_EV: begin
				priority if (dist_q == nb) begin
					status_d = (op_q == OP_PUT) ? STAT_FULL : STAT_NOKEY;
					state_d = S_DONE;
				end else if (e.len == 4'd0 || DW'(e.disp) < dist_q) begin
					// insert point reached
					state_d = S_DONE;
					if (op_q != OP_PUT) begin
						status_d = STAT_NOKEY;
					end else if (CW'(count_q) >= CW'(fill_limit_q)
							|| CW'(count_q) >= CW'(nb)) begin
						status_d = STAT_FULL;
					end else begin
						pos_d = p_sel;
						idx_d = p_sel;
						step_d = '0;
						state_d = S_ROOM_RD;
					end
				end else if (dist_q == DW'(e.disp) && !have_pip_q && e_gt) begin
					pip_d = idx_q;
					have_pip_d = 1'b1;
					idx_d = (idx_q + AW'(1)) & mask;
					dist_d = dist_q + DW'(1);
					state_d = S_PRB_RD;
				end else if (e_eq) begin
					status_d = STAT_OK;
					state_d = S_DONE;
					if (op_q == OP_GET) begin
						vout_d = e.value;
					end else if (op_q == OP_PUT) begin
						if (e.value != nv_q) begin
							vout_d = e.value;
							we = 1'b1;
							wdata = e;
							wdata.value = nv_q;
						end
					end else begin
						vout_d = e.value;
						if (count_q != 11'd0) begin
							count_d = count_q - 11'd1;
						end
						pos_d = idx_q;
						idx_d = (idx_q + AW'(1)) & mask;
						step_d = DW'(1);
						state_d = S_DEL_RD;
					end
				end else begin
					idx_d = (idx_q + AW'(1)) & mask;
					dist_d = dist_q + DW'(1);
					state_d = S_PRB_RD;
				end
			end
			S_ROOM_RD: state_d = S_ROOM_EV;
			S_ROOM_EV: begin
				priority if (step_q == nb) begin
					status_d = STAT_FULL;
					state_d = S_DONE;
				end else if (e.len == 4'd0) begin
					idx_d = pos_q;
					carry_d.len = len_q;
					carry_d.key = key_q;
					carry_d.disp = '0;
					carry_d.value = nv_q;
					dist_d = DW'((pos_q - home_q) & mask);
					state_d = S_INS_RD;
				end else begin
					idx_d = (idx_q + AW'(1)) & mask;
					step_d = step_q + DW'(1);
					state_d = S_ROOM_RD;
				end
			end
			S_INS_RD: state_d = S_INS_EV;
			S_INS_EV: begin
				wdata = carry_q;
				wdata.disp = dist_q[AW-1:0];
				if (e.len == 4'd0) begin
					we = 1'b1;
					count_d = count_q + 11'd1;
					status_d = STAT_OK;
					state_d = S_DONE;
				end else begin
					// poorer incoming entry takes the slot, the old one moves on
					if (dist_q > DW'(e.disp) || (dist_q == DW'(e.disp) && carry_lt)) begin
						we = 1'b1;
						carry_d = e;
						dist_d = DW'(e.disp) + DW'(1);
					end else begin
						dist_d = dist_q + DW'(1);
					end
					idx_d = (idx_q + AW'(1)) & mask;
					state_d = S_INS_RD;
				end
			end
			S_DEL_RD: state_d = S_DEL_EV;
			S_DEL_EV: begin
				we = 1'b1;
				waddr = pos_q;
				if (step_q == nb || e.len == 4'd0 || e.disp == '0) begin
					state_d = S_DONE;
				end else begin
					wdata = e;
					wdata.disp = e.disp - AW'(1);
					pos_d = idx_q;
					idx_d = (idx_q + AW'(1)) & mask;
					step_d = step_q + DW'(1);
					state_d = S_DEL_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			count_q <= '0;
			size_log2_q <= SIZE_LOG2_RST;
			fill_limit_q <= FILL_LIMIT_RST;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			count_q <= count_d;
			if (cfg_we) begin
				if (cfg_index == CFG_SIZE_LOG2) begin
					size_log2_q <= cfg_data[3:0];
				end else begin
					fill_limit_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		pip_q <= pip_d;
		home_q <= home_d;
		have_pip_q <= have_pip_d;
		dist_q <= dist_d;
		step_q <= step_d;
		carry_q <= carry_d;
		op_q <= op_d;
		len_q <= len_d;
		key_q <= key_d;
		nv_q <= nv_d;
		vout_q <= vout_d;
		status_q <= status_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign status = status_q;
	assign value_out = vout_q;
	assign entry_count = count_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction taken without busy");

	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_INVALID || status == STAT_TOOBIG)) |-> $stable(count_q))
		else $error("rejected request changed count");

	a_nokey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NOKEY) |-> (value_out == 32'd0))
		else $error("missing key with value");

endmodule
